// ===== design/ntkh_pkg.sv =====
`default_nettype none

package ntkh_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned ByteW = 8;

  // hash multiplier
  localparam logic [KeyW-1:0] HashMul = KeyW'(43);

  // class codes that come out of the normalizing map
  localparam logic [ByteW-1:0] CodeIgnore   = 8'h01;
  localparam logic [ByteW-1:0] CodeLbracket = 8'h04;
  localparam logic [ByteW-1:0] CodeRbracket = 8'h05;

  localparam logic [ByteW-1:0] CharAmp   = 8'h26;
  localparam logic [ByteW-1:0] CharA     = 8'h61;
  localparam logic [ByteW-1:0] CharN     = 8'h6e;
  localparam logic [ByteW-1:0] CharD     = 8'h64;
  localparam logic [ByteW-1:0] CaseShift = 8'h20;

  // ampersand expands to three hashed letters
  localparam logic [1:0] AmpLastRound = 2'd2;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_IGNORE,
    KIND_LBRACKET,
    KIND_AMP,
    KIND_END
  } byte_kind_e;

  typedef struct packed {
    byte_kind_e       kind;
    logic [ByteW-1:0] code;
  } norm_t;

  typedef enum logic {
    ST_IDLE,
    ST_MIX
  } state_e;

  function automatic logic [ByteW-1:0] amp_code(input logic [1:0] round);
    logic [ByteW-1:0] c;
    unique case (round)
      2'd0:    c = CharA;
      2'd1:    c = CharN;
      default: c = CharD;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/normalized_title_key_hash_unit.sv =====
`default_nettype none

// Normalized title key hash. Feed the bytes of a title one item at a time on
// the slave stream; a byte of zero or an item with tlast high ends the name.
// Letters are folded to lowercase, punctuation such as space, '!', '-', '.',
// ':', '?', '_' and the apostrophe is skipped, and an ampersand is hashed as
// the word "and". Each kept code updates a 64-bit running hash, which starts
// at zero, as h ^ (h*43 + code). The master stream carries a result only in
// two cases: at the end of a name (tuser = 0, the full key, after which the
// hash clears) and just before an opening bracket '(', '[' or '{' is hashed
// (tuser = 1, the prefix key of the title so far). The unit runs one hash round
// per clock in a single shared mix unit: an ordinary byte or an opening bracket
// is accepted and then mixed in one round, an ampersand is accepted and then
// mixed in three rounds, and a skipped byte or an end of name is only accepted.
// The input is not ready while rounds are running. A finished result sits in
// an output register; the input also holds off while a result waits there,
// unless that result is being taken in the same cycle.
module normalized_title_key_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tlast_i,   // end_marker
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] key_hash
  output logic        m_axis_tuser_o    // [0] is_prefix
);

  ntkh_pkg::state_e              state_q, state_d;
  logic [1:0]                    round_q, round_d;
  logic                          amp_q, amp_d;
  logic [ntkh_pkg::ByteW-1:0]    code_q, code_d;
  logic [ntkh_pkg::KeyW-1:0]     hash_q, hash_d;
  logic                          out_valid_q, out_valid_d;
  logic [ntkh_pkg::KeyW-1:0]     out_key_q, out_key_d;
  logic                          out_pre_q, out_pre_d;

  ntkh_pkg::norm_t               norm;
  logic [ntkh_pkg::ByteW-1:0]    mix_code;
  logic [ntkh_pkg::KeyW-1:0]     mix_hash;
  logic                          in_ready;
  logic                          accept;

  ntkh_norm_map u_norm_map (
    .byte_i (s_axis_tdata_i),
    .end_i  (s_axis_tlast_i),
    .norm_o (norm)
  );

  // Ampersand rounds walk through the letters a, n, d; otherwise hash the
  // code captured at accept.
  assign mix_code = amp_q ? ntkh_pkg::amp_code(round_q) : code_q;

  ntkh_mix_unit u_mix_unit (
    .hash_i (hash_q),
    .code_i (mix_code),
    .hash_o (mix_hash)
  );

  // Take a new item only when idle and the output register can hold a result.
  assign in_ready = (state_q == ntkh_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept   = s_axis_tvalid_i && in_ready;

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    amp_d       = amp_q;
    code_d      = code_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_key_d   = out_key_q;
    out_pre_d   = out_pre_q;

    unique case (state_q)
      ntkh_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (norm.kind)
            ntkh_pkg::KIND_END: begin
              out_valid_d = 1'b1;
              out_key_d   = hash_q;
              out_pre_d   = 1'b0;
              hash_d      = '0;
            end
            ntkh_pkg::KIND_LBRACKET: begin
              // Emit the prefix key, then hash the bracket code itself.
              out_valid_d = 1'b1;
              out_key_d   = hash_q;
              out_pre_d   = 1'b1;
              code_d      = norm.code;
              amp_d       = 1'b0;
              round_d     = '0;
              state_d     = ntkh_pkg::ST_MIX;
            end
            ntkh_pkg::KIND_AMP: begin
              amp_d   = 1'b1;
              round_d = '0;
              state_d = ntkh_pkg::ST_MIX;
            end
            ntkh_pkg::KIND_PLAIN: begin
              code_d  = norm.code;
              amp_d   = 1'b0;
              round_d = '0;
              state_d = ntkh_pkg::ST_MIX;
            end
            ntkh_pkg::KIND_IGNORE: begin
              // drop: hash unchanged, no result
            end
            default: begin
            end
          endcase
        end
      end

      ntkh_pkg::ST_MIX: begin
        hash_d = mix_hash;
        if (!amp_q || (round_q == ntkh_pkg::AmpLastRound)) begin
          state_d = ntkh_pkg::ST_IDLE;
        end else begin
          round_d = round_q + 2'd1;
        end
      end

      default: begin
        state_d = ntkh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntkh_pkg::ST_IDLE;
      round_q     <= '0;
      amp_q       <= 1'b0;
      hash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      amp_q       <= amp_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    out_key_q <= out_key_d;
    out_pre_q <= out_pre_d;
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_key_q;
  assign m_axis_tuser_o  = out_pre_q;

endmodule

`default_nettype wire

// ===== design/ntkh_norm_map.sv =====
`default_nettype none

// Byte normalizing map and classification of the mapped code.
module ntkh_norm_map (
  input  logic [ntkh_pkg::ByteW-1:0] byte_i,
  input  logic                       end_i,
  output ntkh_pkg::norm_t            norm_o
);

  logic [ntkh_pkg::ByteW-1:0] code;

  always_comb begin
    case (byte_i) inside
      [8'h41:8'h5a]:
        code = byte_i + ntkh_pkg::CaseShift;
      8'h20, 8'h21, 8'h27, 8'h2d, 8'h2e, 8'h3a, 8'h3f, 8'h5f:
        code = ntkh_pkg::CodeIgnore;
      8'h28, 8'h5b, 8'h7b:
        code = ntkh_pkg::CodeLbracket;
      8'h29, 8'h5d, 8'h7d:
        code = ntkh_pkg::CodeRbracket;
      default:
        code = byte_i;
    endcase
  end

  always_comb begin
    norm_o.code = code;
    if (end_i || (byte_i == '0)) begin
      norm_o.kind = ntkh_pkg::KIND_END;
    end else if (code == ntkh_pkg::CodeIgnore) begin
      norm_o.kind = ntkh_pkg::KIND_IGNORE;
    end else if (code == ntkh_pkg::CodeLbracket) begin
      norm_o.kind = ntkh_pkg::KIND_LBRACKET;
    end else if (code == ntkh_pkg::CharAmp) begin
      norm_o.kind = ntkh_pkg::KIND_AMP;
    end else begin
      norm_o.kind = ntkh_pkg::KIND_PLAIN;
    end
  end

endmodule

`default_nettype wire

// ===== design/ntkh_mix_unit.sv =====
`default_nettype none

// One hash round: h ^ (h*43 + c), modulo 2^64.
module ntkh_mix_unit (
  input  logic [ntkh_pkg::KeyW-1:0]  hash_i,
  input  logic [ntkh_pkg::ByteW-1:0] code_i,
  output logic [ntkh_pkg::KeyW-1:0]  hash_o
);

  logic [ntkh_pkg::KeyW-1:0] prod;

  assign prod   = hash_i * ntkh_pkg::HashMul;
  assign hash_o = hash_i ^ (prod + ntkh_pkg::KeyW'(code_i));

endmodule

`default_nettype wire
